### src/slik_pkg.sv
// Shared constants for the lift/rotation arm inverse kinematics unit.
// Holds register indexes, reset values, angle constants and the CORDIC arctangent table.
// No dependencies.
package slik_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ANGLE_WIDTH_DEF = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LINK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTER_LINK  = 2'd2;

	localparam logic [31:0] BASE_HEIGHT_RST = 32'd0;
	localparam logic [30:0] LINK_LEN_RST    = 31'd19660800;

	// binary angles, 2^31 = pi
	localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

	// ratio of 1.0 in Q2.30, and 1.0 squared in Q4.60
	localparam logic [30:0] RATIO_ONE    = 31'h4000_0000;
	localparam logic [63:0] RATIO_ONE_SQ = 64'h1000_0000_0000_0000;

	// signed width of the CORDIC operands
	localparam int CORDIC_IN_W = 34;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

endpackage

### src/slik_if.sv
// Request channels of the arm inverse kinematics unit: target points in, joint commands out.
// Valid/ready handshake; no dependencies.
interface slik_target_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	logic signed [31:0] current_rotation;

	modport source(output valid, target_x, target_y, target_z, current_rotation, input ready);
	modport sink(input valid, target_x, target_y, target_z, current_rotation, output ready);
endinterface

interface slik_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lift_position;
	logic signed [31:0] rotation_angle;
	logic signed [31:0] arm_angle;
	logic               reach_clamped;

	modport source(output valid, lift_position, rotation_angle, arm_angle, reach_clamped,
		input ready);
	modport sink(input valid, lift_position, rotation_angle, arm_angle, reach_clamped,
		output ready);
endinterface

### src/slik_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage (32 stages).
// Carries a sideband word alongside; no package dependencies.
module slik_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              up_valid,
	input  logic [63:0]       up_val,
	input  logic [SIDE_W-1:0] up_side,
	output logic              dn_valid,
	output logic [31:0]       dn_root,
	output logic [SIDE_W-1:0] dn_side
);
	localparam int STEPS = 32;

	logic              vld_s  [1:STEPS];
	logic [63:0]       rem_s  [1:STEPS];
	logic [63:0]       root_s [1:STEPS];
	logic [SIDE_W-1:0] side_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
		logic              pvld;
		logic [63:0]       prem, proot, trial, nrem, nroot;
		logic [SIDE_W-1:0] pside;

		if (i == 0) begin : g_first
			assign pvld  = up_valid;
			assign prem  = up_val;
			assign proot = '0;
			assign pside = up_side;
		end else begin : g_next
			assign pvld  = vld_s[i];
			assign prem  = rem_s[i];
			assign proot = root_s[i];
			assign pside = side_s[i];
		end

		always_comb begin
			trial = proot + BITV;
			if (prem >= trial) begin
				nrem  = prem - trial;
				nroot = (proot >> 1) + BITV;
			end else begin
				nrem  = prem;
				nroot = proot >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= nrem;
				root_s[i+1] <= nroot;
				side_s[i+1] <= pside;
			end
		end
	end

	assign dn_valid = vld_s[STEPS];
	assign dn_root  = root_s[STEPS][31:0];
	assign dn_side  = side_s[STEPS];
endmodule

### src/slik_div.sv
// Pipelined restoring divider: 30 fraction bits of mag/den for mag < den, one bit per stage.
// Carries a sideband word alongside; no package dependencies.
module slik_div #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              up_valid,
	input  logic [63:0]       up_mag,
	input  logic [63:0]       up_den,
	input  logic [SIDE_W-1:0] up_side,
	output logic              dn_valid,
	output logic [29:0]       dn_quot,
	output logic [SIDE_W-1:0] dn_side
);
	localparam int STEPS = 30;

	logic              vld_s  [1:STEPS];
	logic [63:0]       rem_s  [1:STEPS];
	logic [63:0]       den_s  [1:STEPS];
	logic [29:0]       quot_s [1:STEPS];
	logic [SIDE_W-1:0] side_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic              pvld;
		logic [63:0]       prem, pden, nrem;
		logic [29:0]       pquot, nquot;
		logic [64:0]       dbl;
		logic [SIDE_W-1:0] pside;

		if (i == 0) begin : g_first
			assign pvld  = up_valid;
			assign prem  = up_mag;
			assign pden  = up_den;
			assign pquot = '0;
			assign pside = up_side;
		end else begin : g_next
			assign pvld  = vld_s[i];
			assign prem  = rem_s[i];
			assign pden  = den_s[i];
			assign pquot = quot_s[i];
			assign pside = side_s[i];
		end

		always_comb begin
			dbl = {prem, 1'b0};
			if (dbl >= {1'b0, pden}) begin
				nrem  = 64'(dbl - {1'b0, pden});
				nquot = {pquot[28:0], 1'b1};
			end else begin
				nrem  = dbl[63:0];
				nquot = {pquot[28:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= nrem;
				den_s[i+1]  <= pden;
				quot_s[i+1] <= nquot;
				side_s[i+1] <= pside;
			end
		end
	end

	assign dn_valid = vld_s[STEPS];
	assign dn_quot  = quot_s[STEPS];
	assign dn_side  = side_s[STEPS];
endmodule

### src/slik_cordic.sv
// Pipelined vectoring CORDIC atan2 giving a 32-bit binary angle (39 stages:
// half-plane fold, six normalize steps, 32 rotations). Uses slik_pkg.
module slik_cordic import slik_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          up_valid,
	input  logic signed [CORDIC_IN_W-1:0] up_y,
	input  logic signed [CORDIC_IN_W-1:0] up_x,
	input  logic [SIDE_W-1:0]             up_side,
	output logic                          dn_valid,
	output logic [31:0]                   dn_angle,
	output logic [SIDE_W-1:0]             dn_side
);
	localparam int NORM = 6;
	localparam int ITERS = 32;
	localparam int LAT = 1 + NORM + ITERS;

	logic               vld_s  [1:LAT];
	logic signed [63:0] x_s    [1:LAT];
	logic signed [63:0] y_s    [1:LAT];
	logic [63:0]        m_s    [1:LAT];
	logic [31:0]        z_s    [1:LAT];
	logic               zero_s [1:LAT];
	logic [SIDE_W-1:0]  side_s [1:LAT];

	for (genvar k = 1; k <= LAT; k++) begin : g_st
		logic               pvld, nzero;
		logic signed [63:0] nx, ny;
		logic [63:0]        nm;
		logic [31:0]        nz;
		logic [SIDE_W-1:0]  pside;

		if (k == 1) begin : g_fold
			logic signed [63:0] ex, ey, ay;
			assign pvld  = up_valid;
			assign pside = up_side;
			always_comb begin
				ex = {{(64-CORDIC_IN_W){up_x[CORDIC_IN_W-1]}}, up_x};
				ey = {{(64-CORDIC_IN_W){up_y[CORDIC_IN_W-1]}}, up_y};
				nzero = (ex == 64'sd0) && (ey == 64'sd0);
				if (ex[63]) begin
					nx = -ex;
					ny = -ey;
					nz = HALF_TURN;
				end else begin
					nx = ex;
					ny = ey;
					nz = '0;
				end
				ay = ny[63] ? -ny : ny;
				nm = (nx > ay) ? nx : ay;
			end
		end else if (k <= 1 + NORM) begin : g_norm
			// shift while the larger magnitude stays below 2^59
			localparam int SH = 1 << (1 + NORM - k);
			localparam logic [63:0] LIM = 64'd1 << (59 - SH);
			assign pvld  = vld_s[k-1];
			assign pside = side_s[k-1];
			always_comb begin
				nz    = z_s[k-1];
				nzero = zero_s[k-1];
				if (m_s[k-1] < LIM) begin
					nx = x_s[k-1] <<< SH;
					ny = y_s[k-1] <<< SH;
					nm = m_s[k-1] << SH;
				end else begin
					nx = x_s[k-1];
					ny = y_s[k-1];
					nm = m_s[k-1];
				end
			end
		end else begin : g_rot
			localparam int IT = k - 2 - NORM;
			logic signed [63:0] dx, dy;
			assign pvld  = vld_s[k-1];
			assign pside = side_s[k-1];
			always_comb begin
				dx    = y_s[k-1] >>> IT;
				dy    = x_s[k-1] >>> IT;
				nm    = m_s[k-1];
				nzero = zero_s[k-1];
				if (!y_s[k-1][63] && (y_s[k-1] != 64'sd0)) begin
					nx = x_s[k-1] + dx;
					ny = y_s[k-1] - dy;
					nz = z_s[k-1] + ATAN_TAB[IT];
				end else begin
					nx = x_s[k-1] - dx;
					ny = y_s[k-1] + dy;
					nz = z_s[k-1] - ATAN_TAB[IT];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= nx;
				y_s[k]    <= ny;
				m_s[k]    <= nm;
				z_s[k]    <= nz;
				zero_s[k] <= nzero;
				side_s[k] <= pside;
			end
		end
	end

	assign dn_valid = vld_s[LAT];
	assign dn_angle = zero_s[LAT] ? 32'd0 : z_s[LAT];
	assign dn_side  = side_s[LAT];
endmodule

### src/scara_lift_arm_inverse_kinematics_unit.sv
// Top level of the lift/rotation arm inverse kinematics unit.
// Uses slik_pkg, slik_if, slik_isqrt, slik_div and slik_cordic.
//
//  channel   | dir | handshake        | carries
//  ----------+-----+------------------+----------------------------------------------
//  target    | in  | valid/ready      | target_x/y/z (Q16.16 mm), current_rotation
//  command   | out | valid/ready      | lift_position, rotation_angle, arm_angle,
//            |     |                  | reach_clamped
//  cfg       | in  | cfg_we, no ready | cfg_idx selects register, cfg_wdata is value
//
// One request enters per clock while the output is not held; each passes 183
// register stages. The depth is set by two 39-stage CORDICs, two 32-stage
// square roots and the 30-stage divider in one chain. The whole pipeline
// advances together: when the output register holds an untaken command,
// every stage holds and target.ready drops.
// arst_n clears only the valid bits and the config registers.
module scara_lift_arm_inverse_kinematics_unit import slik_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata,
	slik_target_if.sink          target,
	slik_cmd_if.source           command
);
	// lift saturates to min(COORD_WIDTH, 32) signed bits
	localparam int LIFT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam logic signed [32:0] LIFT_MAX = (33'sd1 <<< (LIFT_W - 1)) - 33'sd1;
	localparam logic signed [32:0] LIFT_MIN = -LIFT_MAX - 33'sd1;
	// angles keep their top ANGLE_WIDTH bits
	localparam logic [31:0] ANGLE_MASK = ~32'd0 << (32 - ANGLE_WIDTH);

	typedef struct packed {
		logic [63:0] rr;
		logic [63:0] mag;
		logic        neg;
		logic        rr0;
		logic [31:0] lift;
		logic [31:0] cur;
	} rot_side_t;

	typedef struct packed {
		logic [63:0] mag;
		logic        neg;
		logic [31:0] lift;
		logic [31:0] rot;
		logic        flipa;
	} rad_side_t;

	typedef struct packed {
		logic        special;
		logic [30:0] sspec;
		logic        clamped;
		logic        neg;
		logic [31:0] lift;
		logic [31:0] rot;
		logic        flipa;
	} div_side_t;

	typedef struct packed {
		logic [31:0] sv;
		logic        clamped;
		logic [31:0] lift;
		logic [31:0] rot;
		logic        flipa;
	} cos_side_t;

	typedef struct packed {
		logic        clamped;
		logic [31:0] lift;
		logic [31:0] rot;
		logic        flipa;
	} arm_side_t;

	// ---------------- configuration registers ----------------
	logic [31:0] base_height_q;
	logic [30:0] inner_link_q;
	logic [30:0] outer_link_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= BASE_HEIGHT_RST;
			inner_link_q  <= LINK_LEN_RST;
			outer_link_q  <= LINK_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BASE_HEIGHT: base_height_q <= cfg_wdata;
				CFG_INNER_LINK:  inner_link_q  <= cfg_wdata[30:0];
				CFG_OUTER_LINK:  outer_link_q  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// global pipeline advance: only a held output stalls
	logic en;
	logic vld_s11;
	assign en = !vld_s11 || command.ready;
	assign target.ready = en;

	// ---------------- S1: squares, lift ----------------
	logic               vld_s1;
	logic signed [31:0] x_s1, y_s1;
	logic [31:0]        lift_s1, cur_s1;
	logic [63:0]        ax2_s1, ay2_s1;
	logic [61:0]        bb_s1, cc_s1;

	logic signed [32:0] lift_full;
	logic [31:0]        lift_sat, ax, ay;

	always_comb begin
		lift_full = {target.target_z[31], target.target_z}
			- {base_height_q[31], base_height_q};
		if (lift_full > LIFT_MAX) begin
			lift_sat = LIFT_MAX[31:0];
		end else if (lift_full < LIFT_MIN) begin
			lift_sat = LIFT_MIN[31:0];
		end else begin
			lift_sat = lift_full[31:0];
		end
		ax = target.target_x[31] ? 32'd0 - target.target_x : target.target_x;
		ay = target.target_y[31] ? 32'd0 - target.target_y : target.target_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= target.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= target.target_x;
			y_s1    <= target.target_y;
			lift_s1 <= lift_sat;
			cur_s1  <= target.current_rotation;
			ax2_s1  <= 64'(ax) * 64'(ax);
			ay2_s1  <= 64'(ay) * 64'(ay);
			bb_s1   <= 62'(inner_link_q) * 62'(inner_link_q);
			cc_s1   <= 62'(outer_link_q) * 62'(outer_link_q);
		end
	end

	// ---------------- S2: r^2 ----------------
	logic               vld_s2;
	logic signed [31:0] x_s2, y_s2;
	logic [31:0]        lift_s2, cur_s2;
	logic [63:0]        rr_s2;
	logic [61:0]        bb_s2, cc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			lift_s2 <= lift_s1;
			cur_s2  <= cur_s1;
			rr_s2   <= ax2_s1 + ay2_s1;
			bb_s2   <= bb_s1;
			cc_s2   <= cc_s1;
		end
	end

	// ---------------- S3: r^2 + b^2 ----------------
	logic               vld_s3;
	logic signed [31:0] x_s3, y_s3;
	logic [31:0]        lift_s3, cur_s3;
	logic [63:0]        rr_s3, p_s3;
	logic [61:0]        cc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			lift_s3 <= lift_s2;
			cur_s3  <= cur_s2;
			rr_s3   <= rr_s2;
			p_s3    <= rr_s2 + {2'b00, bb_s2};
			cc_s3   <= cc_s2;
		end
	end

	// ---------------- S4: |N| and its sign ----------------
	logic               vld_s4;
	logic signed [31:0] x_s4, y_s4;
	rot_side_t          rside_s4;

	logic [63:0] q64;
	assign q64 = {2'b00, cc_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4          <= x_s3;
			y_s4          <= y_s3;
			rside_s4.rr   <= rr_s3;
			rside_s4.neg  <= p_s3 < q64;
			rside_s4.mag  <= (p_s3 < q64) ? q64 - p_s3 : p_s3 - q64;
			rside_s4.rr0  <= rr_s3 == 64'd0;
			rside_s4.lift <= lift_s3;
			rside_s4.cur  <= cur_s3;
		end
	end

	// ---------------- rotation atan2(y, x) ----------------
	logic        rot_vld;
	logic [31:0] rot_ang;
	rot_side_t   rot_side;

	slik_cordic #(.SIDE_W($bits(rot_side_t))) u_cordic_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (vld_s4),
		.up_y     ({{(CORDIC_IN_W-32){y_s4[31]}}, y_s4}),
		.up_x     ({{(CORDIC_IN_W-32){x_s4[31]}}, x_s4}),
		.up_side  (rside_s4),
		.dn_valid (rot_vld),
		.dn_angle (rot_ang),
		.dn_side  (rot_side)
	);

	// ---------------- S5: flip decision ----------------
	// reach backwards when the heading is more than a quarter turn off the
	// present rotation; a zero radius keeps the present rotation
	logic        vld_s5;
	logic [63:0] rr_s5;
	rad_side_t   radside_s5;

	logic [31:0] theta, dtheta;
	logic        flip;

	always_comb begin
		theta  = rot_ang - QUARTER_TURN;
		dtheta = theta - rot_side.cur;
		flip   = (dtheta > QUARTER_TURN) && (dtheta < THREE_QUARTER_TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= rot_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s5            <= rot_side.rr;
			radside_s5.mag   <= rot_side.mag;
			radside_s5.neg   <= rot_side.neg;
			radside_s5.lift  <= rot_side.lift;
			radside_s5.rot   <= rot_side.rr0 ? rot_side.cur
				: (flip ? theta + HALF_TURN : theta);
			radside_s5.flipa <= flip && !rot_side.rr0;
		end
	end

	// ---------------- radius = floor(sqrt(r^2)) ----------------
	logic        rad_vld;
	logic [31:0] rad_root;
	rad_side_t   rad_side;

	slik_isqrt #(.SIDE_W($bits(rad_side_t))) u_isqrt_rad (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (vld_s5),
		.up_val   (rr_s5),
		.up_side  (radside_s5),
		.dn_valid (rad_vld),
		.dn_root  (rad_root),
		.dn_side  (rad_side)
	);

	// ---------------- S6: denominator 2*R*b ----------------
	logic        vld_s6;
	logic [63:0] den_s6;
	rad_side_t   radside_s6;
	logic [62:0] rb_prod;

	assign rb_prod = 63'(rad_root) * 63'(inner_link_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= rad_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6     <= {rb_prod, 1'b0};
			radside_s6 <= rad_side;
		end
	end

	// ---------------- S7: ratio special cases ----------------
	// zero denominator: nonzero N clamps; |N| above den clamps; |N| equal
	// den gives exactly one without a flag; otherwise divide
	logic        vld_s7;
	logic [63:0] mag_s7, den_s7;
	div_side_t   divside_s7;

	logic den0, mag_gt, mag_eq, mag0;

	always_comb begin
		den0   = den_s6 == 64'd0;
		mag0   = radside_s6.mag == 64'd0;
		mag_gt = radside_s6.mag > den_s6;
		mag_eq = radside_s6.mag == den_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s7             <= radside_s6.mag;
			den_s7             <= den_s6;
			divside_s7.special <= den0 || mag_gt || mag_eq;
			divside_s7.sspec   <= (den0 && mag0) ? 31'd0 : RATIO_ONE;
			divside_s7.clamped <= den0 ? !mag0 : mag_gt;
			divside_s7.neg     <= radside_s6.neg;
			divside_s7.lift    <= radside_s6.lift;
			divside_s7.rot     <= radside_s6.rot;
			divside_s7.flipa   <= radside_s6.flipa;
		end
	end

	// ---------------- ratio |N| / (2 R b), Q2.30 ----------------
	logic        div_vld;
	logic [29:0] div_quot;
	div_side_t   div_side;

	slik_div #(.SIDE_W($bits(div_side_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (vld_s7),
		.up_mag   (mag_s7),
		.up_den   (den_s7),
		.up_side  (divside_s7),
		.dn_valid (div_vld),
		.dn_quot  (div_quot),
		.dn_side  (div_side)
	);

	// ---------------- S8: pick ratio ----------------
	logic        vld_s8;
	logic [30:0] s_s8;
	logic        neg_s8;
	arm_side_t   aside_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s8             <= div_side.special ? div_side.sspec : {1'b0, div_quot};
			neg_s8           <= div_side.neg;
			aside_s8.clamped <= div_side.clamped;
			aside_s8.lift    <= div_side.lift;
			aside_s8.rot     <= div_side.rot;
			aside_s8.flipa   <= div_side.flipa;
		end
	end

	// ---------------- S9: s^2 and signed sine ----------------
	logic        vld_s9;
	logic [61:0] ss_s9;
	logic [31:0] sv_s9;
	arm_side_t   aside_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s9    <= 62'(s_s8) * 62'(s_s8);
			sv_s9    <= neg_s8 ? 32'd0 - {1'b0, s_s8} : {1'b0, s_s8};
			aside_s9 <= aside_s8;
		end
	end

	// ---------------- S10: 1 - s^2 ----------------
	logic        vld_s10;
	logic [63:0] v_s10;
	cos_side_t   cside_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s10             <= RATIO_ONE_SQ - {2'b00, ss_s9};
			cside_s10.sv      <= sv_s9;
			cside_s10.clamped <= aside_s9.clamped;
			cside_s10.lift    <= aside_s9.lift;
			cside_s10.rot     <= aside_s9.rot;
			cside_s10.flipa   <= aside_s9.flipa;
		end
	end

	// ---------------- cosine = sqrt(1 - s^2) ----------------
	logic        cos_vld;
	logic [31:0] cos_root;
	cos_side_t   cos_side;

	slik_isqrt #(.SIDE_W($bits(cos_side_t))) u_isqrt_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (vld_s10),
		.up_val   (v_s10),
		.up_side  (cside_s10),
		.dn_valid (cos_vld),
		.dn_root  (cos_root),
		.dn_side  (cos_side)
	);

	// ---------------- asin as atan2(s, cos) ----------------
	logic        arm_vld;
	logic [31:0] arm_ang;
	arm_side_t   arm_side, arm_in_side;

	always_comb begin
		arm_in_side.clamped = cos_side.clamped;
		arm_in_side.lift    = cos_side.lift;
		arm_in_side.rot     = cos_side.rot;
		arm_in_side.flipa   = cos_side.flipa;
	end

	slik_cordic #(.SIDE_W($bits(arm_side_t))) u_cordic_arm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (cos_vld),
		.up_y     ({{(CORDIC_IN_W-32){cos_side.sv[31]}}, cos_side.sv}),
		.up_x     ({{(CORDIC_IN_W-32){1'b0}}, cos_root}),
		.up_side  (arm_in_side),
		.dn_valid (arm_vld),
		.dn_angle (arm_ang),
		.dn_side  (arm_side)
	);

	// ---------------- S11: output register ----------------
	// a backwards reach mirrors the arm angle
	logic [31:0] lift_s11, rot_s11, arm_s11;
	logic        clamped_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= arm_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lift_s11    <= arm_side.lift;
			rot_s11     <= arm_side.rot & ANGLE_MASK;
			arm_s11     <= (arm_side.flipa ? 32'd0 - arm_ang : arm_ang) & ANGLE_MASK;
			clamped_s11 <= arm_side.clamped;
		end
	end

	assign command.valid          = vld_s11;
	assign command.lift_position  = lift_s11;
	assign command.rotation_angle = rot_s11;
	assign command.arm_angle      = arm_s11;
	assign command.reach_clamped  = clamped_s11;
endmodule

### tb/sv/scara_lift_arm_inverse_kinematics_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scara_lift_arm_inverse_kinematics_unit.
// Directed table, then random targets over several register settings.
// Results are checked against a built-in bit-exact predictor. Needs slik_pkg, slik_if and the RTL.
module scara_lift_arm_inverse_kinematics_unit_tb;
	import slik_pkg::*;

	localparam int LATENCY   = 183;
	localparam int WD_LIMIT  = 4000;
	localparam int N_PHASES  = 6;
	localparam int PHASE_LEN = 160;
	// unused register slot; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [31:0] lift;
		logic signed [31:0] rot;
		logic signed [31:0] arm;
		logic               clamp;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] cur;
		logic               typed;
		cmd_t               want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	slik_target_if target();
	slik_cmd_if    command();

	scara_lift_arm_inverse_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .target(target.sink), .command(command.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copies of the configuration registers
	logic signed [31:0] base_h = BASE_HEIGHT_RST;
	logic [30:0]        link_b = LINK_LEN_RST;
	logic [30:0]        link_c = LINK_LEN_RST;

	cmd_t cmd_q[$];
	int   errors = 0;
	int   wd_count = 0;
	bit   idle_on = 1'b1;
	int   stall_left = 0;

	initial begin
		target.valid = 1'b0;
		target.target_x = '0;
		target.target_y = '0;
		target.target_z = '0;
		target.current_rotation = '0;
		command.ready = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// vectoring CORDIC; operands below 2^33 in magnitude
	function automatic logic [31:0] bin_atan2(longint y, longint x);
		logic [31:0] ang;
		longint m, ay, dx, dy;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = HALF_TURN;
		end
		ay = (y < 0) ? -y : y;
		m = (x > ay) ? x : ay;
		while (m < (64'sd1 <<< 58)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				ang = ang + ATAN_TAB[i];
			end else begin
				x = x - dx;
				y = y + dy;
				ang = ang - ATAN_TAB[i];
			end
		end
		return ang;
	endfunction

	function automatic cmd_t predict_joints(logic signed [31:0] tx, logic signed [31:0] ty,
			logic signed [31:0] tz, logic [31:0] cur);
		cmd_t o;
		longint lift, sv;
		logic [63:0] ax, ay, rr, b, c, p, q, mag, den, s, rem;
		logic [31:0] theta, d, arm;
		logic flip, neg, clamped;
		lift = longint'(tz) - longint'(base_h);
		if (lift > 64'sd2147483647) lift = 64'sd2147483647;
		if (lift < -64'sd2147483648) lift = -64'sd2147483648;
		ax = (tx < 0) ? -longint'(tx) : longint'(tx);
		ay = (ty < 0) ? -longint'(ty) : longint'(ty);
		rr = ax * ax + ay * ay;
		b = link_b;
		c = link_c;
		clamped = 1'b0;

		theta = bin_atan2(ty, tx) - QUARTER_TURN;
		d = theta - cur;
		// strictly beyond a quarter turn away: reach backwards
		flip = d > QUARTER_TURN && d < THREE_QUARTER_TURN;
		if (flip) theta = theta + HALF_TURN;

		// law of cosines ratio, Q2.30 magnitude
		p = rr + b * b;
		q = c * c;
		neg = p < q;
		mag = neg ? q - p : p - q;
		den = 2 * (isqrt(rr) * b);
		if (den == 0) begin
			clamped = mag != 0;
			s = clamped ? 64'(RATIO_ONE) : 0;
		end else if (mag > den) begin
			clamped = 1'b1;
			s = 64'(RATIO_ONE);
		end else if (mag == den) begin
			s = 64'(RATIO_ONE);
		end else begin
			rem = mag;
			s = 0;
			for (int i = 0; i < 30; i++) begin
				s = s << 1;
				if (rem >= den - rem) begin
					s = s | 1;
					rem = rem - (den - rem);
				end else begin
					rem = rem + rem;
				end
			end
		end
		sv = neg ? -longint'(s) : longint'(s);
		arm = bin_atan2(sv, longint'(isqrt(RATIO_ONE_SQ - s * s)));
		if (flip && rr != 0) arm = 32'd0 - arm;

		o.lift = lift[31:0];
		o.rot = (rr == 0) ? cur : theta;
		o.arm = arm;
		o.clamp = clamped;
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Output side: ready bursts at the falling edge, checks at the rising edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			command.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 7) - 1;
			command.ready <= 1'b0;
		end else begin
			command.ready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		cmd_t w;
		if (command.valid && command.ready) begin
			if (cmd_q.size() == 0) begin
				$display("unexpected command at %0t", $realtime);
				errors++;
			end else begin
				w = cmd_q.pop_front();
				if (command.lift_position !== w.lift)
					report_mismatch("lift_position", command.lift_position, w.lift);
				if (command.rotation_angle !== w.rot)
					report_mismatch("rotation_angle", command.rotation_angle, w.rot);
				if (command.arm_angle !== w.arm)
					report_mismatch("arm_angle", command.arm_angle, w.arm);
				if (command.reach_clamped !== w.clamp)
					report_mismatch("reach_clamped", 32'(command.reach_clamped),
						32'(w.clamp));
			end
		end
		// watchdog: cycles with no request moving on either side
		if ((command.valid && command.ready) || (target.valid && target.ready)) begin
			wd_count <= 0;
		end else if (wd_count >= WD_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			wd_count <= wd_count + 1;
		end
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------
	task automatic send_target(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [31:0] cur, logic typed, cmd_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			target.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		target.valid <= 1'b1;
		target.target_x <= x;
		target.target_y <= y;
		target.target_z <= z;
		target.current_rotation <= cur;
		@(posedge clk);
		while (!target.ready) @(posedge clk);
		cmd_q.push_back(typed ? want : predict_joints(x, y, z, cur));
		@(negedge clk);
	endtask

	// wait for every command, then let the pipeline settle
	task automatic drain();
		target.valid <= 1'b0;
		while (cmd_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_BASE_HEIGHT: base_h = val;
			CFG_INNER_LINK:  link_b = val[30:0];
			CFG_OUTER_LINK:  link_c = val[30:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// random coordinate: full range, within reach, or near the axis
	function automatic logic signed [31:0] rand_coord(int mode);
		longint lim;
		lim = longint'(link_b) + longint'(link_c) + 1;
		if (lim > 64'sd2147483647) lim = 64'sd2147483647;
		case (mode)
			0: return $urandom;
			1: return 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
			default: return $signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4;
		endcase
	endfunction

	// directed rows under the reset links (b = c = 300 mm)
	localparam row_t DIRECTED [14] = '{
		// origin: rotation holds, ratio zero
		'{32'sd0, 32'sd0, 32'sd0, 32'h0, 1'b0, '0},
		'{32'sd0, 32'sd0, 32'sd5, 32'h12345678, 1'b0, '0},
		// field extremes
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0},
		'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0},
		'{32'sd0, 32'h80000000, 32'sd0, 32'hFFFFFFFF, 1'b0, '0},
		// fully stretched arm: ratio exactly one
		'{32'sd39321600, 32'sd0, 32'sd0, 32'hC0000000, 1'b0, '0},
		// exactly a quarter turn off, both sides: no flip
		'{32'sd6553600, 32'sd0, 32'sd0, 32'h00000000, 1'b0, '0},
		'{32'sd6553600, 32'sd0, 32'sd0, 32'h80000000, 1'b0, '0},
		// target behind the arm: flip
		'{-32'sd6553600, 32'sd0, 32'sd0, 32'hC0000000, 1'b0, '0},
		'{32'sd0, 32'sd3276800, 32'sd0, 32'h80000000, 1'b0, '0},
		// out of reach: clamped
		'{32'sd65536000, 32'sd1, -32'sd100, 32'h0, 1'b0, '0},
		// tiny radii
		'{32'sd1, 32'sd0, 32'sd0, 32'h0, 1'b0, '0},
		'{-32'sd1, -32'sd1, 32'sd0, 32'h40000000, 1'b0, '0},
		'{32'sd0, 32'sd1, 32'sd0, 32'hBFFFFFFF, 1'b0, '0}
	};

	initial begin
		logic [31:0] cfg_set [N_PHASES][3];
		int mode;
		cfg_set[0] = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000};
		cfg_set[1] = '{32'h7FFFFFFF, 32'h00000001, 32'h7FFFFFFF};
		cfg_set[2] = '{$urandom, $urandom, $urandom};
		cfg_set[3] = '{$urandom, 32'($urandom_range(1, 1 << 24)),
			32'($urandom_range(0, 1 << 24))};
		cfg_set[4] = '{32'hFFFF0000, 32'($urandom_range(1 << 20, 1 << 26)),
			32'($urandom_range(1 << 20, 1 << 26))};
		cfg_set[5] = '{$urandom, 32'($urandom_range(1 << 16, 1 << 25)),
			32'($urandom_range(1 << 16, 1 << 25))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values first
		foreach (DIRECTED[i])
			send_target(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, DIRECTED[i].cur,
				DIRECTED[i].typed, DIRECTED[i].want);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(CFG_BASE_HEIGHT, cfg_set[ph][0]);
			write_reg(CFG_INNER_LINK, cfg_set[ph][1]);
			write_reg(CFG_OUTER_LINK, cfg_set[ph][2]);
			write_reg(CFG_UNUSED, $urandom);
			cfg_we <= 1'b0;
			@(negedge clk);
			// no idling at all in the final phase
			idle_on = (ph != N_PHASES - 1);
			for (int n = 0; n < PHASE_LEN; n++) begin
				mode = $urandom_range(0, 9);
				mode = (mode < 3) ? 0 : (mode < 8) ? 1 : 2;
				send_target(rand_coord(mode), rand_coord(mode),
					($urandom_range(0, 1) != 0) ? $urandom : rand_coord(2),
					$urandom, 1'b0, '0);
			end
			drain();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### scara_lift_arm_inverse_kinematics_unit.f
src/slik_pkg.sv
src/slik_if.sv
src/slik_isqrt.sv
src/slik_div.sv
src/slik_cordic.sv
src/scara_lift_arm_inverse_kinematics_unit.sv
tb/sv/scara_lift_arm_inverse_kinematics_unit_tb.sv
